/* hdl/olde_pkg.sv */
// Shared types and constants for the ordered list deque engine.
// Holds function codes, status codes, the internal operation type and the
// command beat that travels from the front end to the back end.
package olde_pkg;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_SEARCH,
        OP_REMOVE,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

/* hdl/olde_front.sv */
// Front end: takes input beats, decodes the function code into an
// operation and holds the command until the queue takes it.
// Depends on olde_pkg.
module olde_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [olde_pkg::FUNC_W-1:0]        func,
    input  logic signed [olde_pkg::VALUE_W-1:0] value,
    output logic                               push,
    output olde_pkg::cmd_t                     cmd,
    input  logic                               q_full
);

    logic           vld_reg;
    logic           vld_next;
    olde_pkg::cmd_t cmd_reg;
    olde_pkg::cmd_t cmd_next;
    olde_pkg::op_t  op_dec;
    logic           take;

    always_comb
    begin
        unique case (func)
            olde_pkg::FUNC_PUSH_FRONT: op_dec = olde_pkg::OP_PUSH_FRONT;
            olde_pkg::FUNC_PUSH_BACK:  op_dec = olde_pkg::OP_PUSH_BACK;
            olde_pkg::FUNC_POP_FRONT:  op_dec = olde_pkg::OP_POP_FRONT;
            olde_pkg::FUNC_POP_BACK:   op_dec = olde_pkg::OP_POP_BACK;
            olde_pkg::FUNC_SEARCH:     op_dec = olde_pkg::OP_SEARCH;
            olde_pkg::FUNC_REMOVE:     op_dec = olde_pkg::OP_REMOVE;
            default:                   op_dec = olde_pkg::OP_NOP;
        endcase
    end

    assign in_stall = vld_reg & q_full;
    assign take     = in_valid & ~in_stall;
    assign push     = vld_reg & ~q_full;
    assign cmd      = cmd_reg;

    always_comb
    begin
        vld_next = vld_reg & q_full;
        cmd_next = cmd_reg;
        if (take)
        begin
            vld_next       = 1'b1;
            cmd_next.op    = op_dec;
            cmd_next.value = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

/* hdl/olde_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on olde_pkg for the command beat type and queue sizing.
module olde_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  olde_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output olde_pkg::cmd_t q_cmd
);

    olde_pkg::cmd_t                    slot_mem [olde_pkg::QUEUE_DEPTH];
    logic [olde_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [olde_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [olde_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [olde_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [olde_pkg::QCNT_W-1:0]       cnt_reg;
    logic [olde_pkg::QCNT_W-1:0]       cnt_next;
    logic                              do_pop;

    assign full    = cnt_reg == olde_pkg::QCNT_W'(olde_pkg::QUEUE_DEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_cmd   = slot_mem[rd_ptr_reg];
    assign do_pop  = pop & q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/olde_back.sv */
// Back end: list storage as a circular buffer in a memory, with a sequencer
// that runs pushes, pops, scans and compaction, and the result register.
// Depends on olde_pkg.
module olde_back
#(
    parameter int LIST_DEPTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  olde_pkg::cmd_t                      q_cmd,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [olde_pkg::STATUS_W-1:0]       status,
    output logic signed [olde_pkg::VALUE_W-1:0] result_value,
    output logic [olde_pkg::POS_W-1:0]          position,
    output logic [olde_pkg::POS_W-1:0]          fill_level
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(LIST_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(LIST_DEPTH);
    localparam logic [SW-1:0] WRAP_SUM  = SW'(LIST_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_CK,
        S_SCAN_RD,
        S_SCAN_CK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } state_t;

    logic [olde_pkg::VALUE_W-1:0] mem [LIST_DEPTH];
    logic [olde_pkg::VALUE_W-1:0] rdata_reg;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [olde_pkg::VALUE_W-1:0] mem_wdata;

    state_t                        state_reg, state_next;
    olde_pkg::op_t                 op_reg, op_next;
    logic [olde_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [AW-1:0]                 wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [olde_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [olde_pkg::VALUE_W-1:0]  rv_reg, rv_next;
    logic [olde_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                          out_valid_reg, out_valid_next;
    logic [olde_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [olde_pkg::VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [olde_pkg::POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [olde_pkg::POS_W-1:0]    out_fill_reg, out_fill_next;

    logic          full;
    logic          empty;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] ptr_inc;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] cnt_dec;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] last_addr;

    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;
    assign head_inc = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_ADDR : head_reg - 1'b1;
    assign ptr_inc  = (ptr_reg == LAST_ADDR) ? '0 : ptr_reg + 1'b1;
    assign idx_inc  = idx_reg + 1'b1;
    assign cnt_dec  = count_reg - 1'b1;
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign last_sum = SW'(head_reg) + SW'(cnt_dec);
    assign tail_addr = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : AW'(tail_sum);
    assign last_addr = (last_sum >= WRAP_SUM) ? AW'(last_sum - WRAP_SUM) : AW'(last_sum);

    assign q_pop        = (state_reg == S_IDLE) & q_valid;
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_value_reg;
    assign position     = out_pos_reg;
    assign fill_level   = out_fill_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        idx_next        = idx_reg;
        st_next         = st_reg;
        rv_next         = rv_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg & out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_pos_next    = out_pos_reg;
        out_fill_next   = out_fill_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_ptr_reg;
        mem_wdata       = rdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next    = q_cmd.op;
                    value_next = q_cmd.value;
                    st_next    = olde_pkg::ST_OK;
                    rv_next    = '0;
                    pos_next   = '0;
                    state_next = S_OUT;
                    unique case (q_cmd.op) inside
                        olde_pkg::OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                st_next = olde_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = head_dec;
                                mem_wdata  = q_cmd.value;
                                head_next  = head_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        olde_pkg::OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                st_next = olde_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = tail_addr;
                                mem_wdata  = q_cmd.value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        olde_pkg::OP_POP_FRONT, olde_pkg::OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                st_next = olde_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = (q_cmd.op == olde_pkg::OP_POP_FRONT) ?
                                             head_reg : last_addr;
                                state_next = S_POP_RD;
                            end
                        end
                        olde_pkg::OP_SEARCH, olde_pkg::OP_REMOVE:
                        begin
                            if (empty)
                            begin
                                st_next = olde_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                ptr_next   = head_reg;
                                idx_next   = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP_RD:
            begin
                state_next = S_POP_CK;
            end
            S_POP_CK:
            begin
                rv_next    = rdata_reg;
                count_next = cnt_dec;
                if (op_reg == olde_pkg::OP_POP_FRONT)
                begin
                    head_next = head_inc;
                end
                state_next = S_OUT;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                if (rdata_reg == value_reg)
                begin
                    rv_next  = rdata_reg;
                    pos_next = olde_pkg::POS_W'(idx_inc);
                    if (op_reg == olde_pkg::OP_REMOVE)
                    begin
                        wr_ptr_next = ptr_reg;
                        ptr_next    = ptr_inc;
                        idx_next    = idx_inc;
                        state_next  = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    st_next    = olde_pkg::ST_NOT_FOUND;
                    state_next = S_OUT;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = cnt_dec;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = wr_ptr_reg;
                mem_wdata   = rdata_reg;
                wr_ptr_next = ptr_reg;
                ptr_next    = ptr_inc;
                idx_next    = idx_inc;
                state_next  = S_SHIFT_RD;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_value_next  = rv_reg;
                    out_pos_next    = pos_reg;
                    out_fill_next   = olde_pkg::POS_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        ptr_reg        <= ptr_next;
        wr_ptr_reg     <= wr_ptr_next;
        idx_reg        <= idx_next;
        st_reg         <= st_next;
        rv_reg         <= rv_next;
        pos_reg        <= pos_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_pos_reg    <= out_pos_next;
        out_fill_reg   <= out_fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[ptr_reg];
    end

endmodule

/* hdl/ordered_list_deque_engine.sv */
// Ordered list deque engine: a push writes the list and goes straight to the result register;
// a pop reads one entry, then checks it; a search reads and compares each entry in turn; a remove
// then moves each later entry up with a read and a write. These steps come from the registered list memory read.
// The front end takes beats while the back end works, up to the queue depth plus the one it holds.
// Reset empties the list and the queue; list memory contents are not cleared.
// Depends on olde_pkg, olde_front, olde_queue and olde_back.
module ordered_list_deque_engine
#(
    parameter int LIST_DEPTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [olde_pkg::FUNC_W-1:0]         func,
    input  logic signed [olde_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [olde_pkg::STATUS_W-1:0]       status,
    output logic signed [olde_pkg::VALUE_W-1:0] result_value,
    output logic [olde_pkg::POS_W-1:0]          position,
    output logic [olde_pkg::POS_W-1:0]          fill_level
);

    logic           f_push;
    olde_pkg::cmd_t f_cmd;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    olde_pkg::cmd_t q_cmd;

    olde_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .value    (value),
        .push     (f_push),
        .cmd      (f_cmd),
        .q_full   (q_full)
    );

    olde_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_cmd (f_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    olde_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_value (result_value),
        .position     (position),
        .fill_level   (fill_level)
    );

    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != olde_pkg::ST_OK |-> result_value == '0 && position == '0)
        else $error("result value or position set on a failed operation");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == olde_pkg::ST_EMPTY |-> fill_level == '0)
        else $error("empty status with nonzero fill level");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == olde_pkg::ST_FULL |->
            fill_level == olde_pkg::POS_W'(LIST_DEPTH))
        else $error("full status below capacity");

    a_queue_safe: assert property (@(posedge clk) disable iff (!rst_n)
        q_full && !q_pop |=> !f_push || q_full)
        else $error("queue pointer state inconsistent");

endmodule
